// ===== sv/dskl_pkg.sv =====
package dskl_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned K_W = 5;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	localparam logic [ADDR_W-1:0] ADDR_K_COUNT = 3'd0;
	localparam logic [K_W-1:0] K_RESET = 5'd1;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef struct packed {
		logic vld;
		logic signed [VAL_W-1:0] val;
	} ins_t;

endpackage

// ===== sv/dskl_parser.sv =====
module dskl_parser (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic [7:0] in_byte,
	output dskl_pkg::ins_t ins_q
);

	localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	logic [31:0] acc_q;
	logic neg_q;
	logic pending_q;
	logic started_q;
	logic closed_q;

	logic is_sep;
	logic is_digit;
	logic is_blank;
	logic is_sign;
	logic [3:0] digit;
	logic [35:0] mul;
	logic [31:0] acc_next;
	logic signed [31:0] tok_val;

	always_comb begin
		is_sep = (in_byte == dskl_pkg::CH_NUL) || (in_byte == dskl_pkg::CH_SPACE)
			|| (in_byte == dskl_pkg::CH_NL);
		is_digit = (in_byte >= dskl_pkg::CH_ZERO) && (in_byte <= dskl_pkg::CH_NINE);
		is_blank = (in_byte == dskl_pkg::CH_TAB) || (in_byte == dskl_pkg::CH_VT)
			|| (in_byte == dskl_pkg::CH_FF) || (in_byte == dskl_pkg::CH_CR);
		is_sign = (in_byte == dskl_pkg::CH_PLUS) || (in_byte == dskl_pkg::CH_MINUS);
		digit = 4'(in_byte - dskl_pkg::CH_ZERO);
		// times ten as two shifts
		mul = (36'(acc_q) << 3) + (36'(acc_q) << 1) + 36'(digit);
		acc_next = (mul > MAG_LIMIT) ? MAG_LIMIT[31:0] : mul[31:0];
		if (neg_q) begin
			tok_val = 32'(32'd0 - acc_q);
		end else begin
			tok_val = (acc_q > POS_MAX) ? POS_MAX : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			neg_q <= 1'b0;
			pending_q <= 1'b0;
			started_q <= 1'b0;
			closed_q <= 1'b0;
			ins_q.vld <= 1'b0;
			ins_q.val <= '0;
		end else begin
			ins_q.vld <= 1'b0;
			if (take) begin
				if (is_sep) begin
					// hand the finished token to the chain, drop empty ones
					ins_q.vld <= pending_q;
					ins_q.val <= tok_val;
					acc_q <= '0;
					neg_q <= 1'b0;
					pending_q <= 1'b0;
					started_q <= 1'b0;
					closed_q <= 1'b0;
				end else begin
					pending_q <= 1'b1;
					if (!closed_q) begin
						priority if (is_digit) begin
							acc_q <= acc_next;
							started_q <= 1'b1;
						end else if (started_q) begin
							closed_q <= 1'b1;
						end else if (is_blank) begin
							closed_q <= 1'b0;
						end else if (is_sign) begin
							neg_q <= (in_byte == dskl_pkg::CH_MINUS);
							started_q <= 1'b1;
						end else begin
							closed_q <= 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

// ===== sv/dskl_cell.sv =====
module dskl_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  dskl_pkg::ins_t up,
	output logic signed [dskl_pkg::VAL_W-1:0] held_q,
	output dskl_pkg::ins_t down_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			down_q.vld <= 1'b0;
			down_q.val <= '0;
		end else if (clr) begin
			held_q <= '0;
			down_q.vld <= 1'b0;
		end else begin
			down_q.vld <= up.vld;
			if (up.vld) begin
				// keep the larger, pass the smaller on
				if (held_q < up.val) begin
					held_q <= up.val;
					down_q.val <= held_q;
				end else begin
					down_q.val <= up.val;
				end
			end
		end
	end

endmodule

// ===== sv/decimal_stream_kth_largest.sv =====
// Streaming k-th largest of decimal tokens.
// Input channel: in_byte with in_valid/in_ready, one ASCII byte per transaction.
// Space or newline ends a token; the token is parsed as atoi does and inserted
// into a descending list held in a chain of LIST_DEPTH compare-and-swap cells.
// A zero byte inserts any pending token and produces one transaction on the
// output channel (kth_value with out_valid/out_ready): entry k of the list.
// Throughput: one byte per cycle for all non-zero bytes. After a zero byte the
// input stalls until the last insertion has passed the whole cell chain; then
// the result is loaded into the output register, which drives kth_value
// directly, and the list is cleared.
// k_count is written over the APB port at address 0 (reset value 1); values
// of 0 act as 1 and values above LIST_DEPTH act as LIST_DEPTH.
// Reset clears the list, the token state and the output register.
// If the receiver stalls, the result waits in the output register and the
// next stream is taken; a second zero byte waits until that result is gone.
module decimal_stream_kth_largest #(
	parameter int unsigned LIST_DEPTH = dskl_pkg::DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dskl_pkg::ADDR_W-1:0] paddr,
	input  logic [dskl_pkg::DATA_W-1:0] pwdata,
	output logic [dskl_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] in_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [dskl_pkg::VAL_W-1:0] kth_value
);

	localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic ST_RUN = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic st_q;
	logic [dskl_pkg::K_W-1:0] k_q;
	logic out_valid_q;
	logic signed [dskl_pkg::VAL_W-1:0] kth_q;

	logic take;
	logic busy;
	logic load;
	logic [IDX_W-1:0] idx;

	dskl_pkg::ins_t link [0:LIST_DEPTH];
	logic signed [dskl_pkg::VAL_W-1:0] held [0:LIST_DEPTH-1];
	logic [LIST_DEPTH:0] link_vld;

	assign pready = 1'b1;
	assign prdata = (paddr == dskl_pkg::ADDR_K_COUNT) ? dskl_pkg::DATA_W'(k_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= dskl_pkg::K_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr == dskl_pkg::ADDR_K_COUNT)) begin
			k_q <= pwdata[dskl_pkg::K_W-1:0];
		end
	end

	assign in_ready = (st_q == ST_RUN);
	assign take = in_valid && in_ready;

	dskl_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (in_byte),
		.ins_q   (link[0])
	);

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		dskl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (load),
			.up     (link[i]),
			.held_q (held[i]),
			.down_q (link[i+1])
		);
	end

	for (genvar i = 0; i <= LIST_DEPTH; i++) begin : g_vld
		assign link_vld[i] = link[i].vld;
	end

	assign busy = |link_vld;
	assign load = (st_q == ST_DRAIN) && !busy && (!out_valid_q || out_ready);

	always_comb begin
		int sel;
		sel = int'(k_q);
		if (sel < 1) begin
			sel = 1;
		end
		if (sel > int'(LIST_DEPTH)) begin
			sel = int'(LIST_DEPTH);
		end
		idx = IDX_W'(sel - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_RUN: begin
					if (take && (in_byte == dskl_pkg::CH_NUL)) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load) begin
						st_q <= ST_RUN;
					end
				end
				default: st_q <= ST_RUN;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kth_q <= '0;
		end else if (load) begin
			kth_q <= held[idx];
		end
	end

	assign out_valid = out_valid_q;
	assign kth_value = kth_q;

endmodule
